>>> design/tomek_link_clean_knn_classify_assert.svh
// Assertion macros shared by the Tomek-link cleaning and k-NN vote design.
`ifndef TOMEK_LINK_CLEAN_KNN_CLASSIFY_ASSERT_SVH
`define TOMEK_LINK_CLEAN_KNN_CLASSIFY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlk: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlk: next-cycle check failed");

`endif

>>> design/tlk_pkg.sv
// Shared constants for the Tomek-link cleaning and k-NN vote design.
package tlk_pkg;
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 6;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = 7;
  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam int KEY_W = DIST_W + IDX_W;
  localparam int PT_W = 2 * COORD_BITS + 1;
  localparam int NN_W = IDX_W + 1;
  localparam logic [3:0] K_RESET = 4'd10;
  localparam logic REG_K_NEIGHBORS = 1'b0;
endpackage

>>> design/tlk_ram.sv
// Generic single-write, single-read memory with registered read data.
module tlk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/tlk_dist.sv
// Shared distance unit: squared distance and ordered-key candidate compare.
module tlk_dist
  import tlk_pkg::*;
(
  input  logic [COORD_BITS-1:0] xi,
  input  logic [COORD_BITS-1:0] yi,
  input  logic [COORD_BITS-1:0] xj,
  input  logic [COORD_BITS-1:0] yj,
  input  logic [IDX_W-1:0]      jidx,
  input  logic                  have_prev,
  input  logic [KEY_W-1:0]      prev_key,
  input  logic                  found,
  input  logic [KEY_W-1:0]      best_key,
  output logic [KEY_W-1:0]      key,
  output logic                  take
);
  logic [COORD_BITS-1:0]   adx, ady;
  logic [2*COORD_BITS-1:0] sqx, sqy;
  logic [DIST_W-1:0]       sum_sq;

  always_comb begin
    adx    = (xi >= xj) ? xi - xj : xj - xi;
    ady    = (yi >= yj) ? yi - yj : yj - yi;
    sqx    = adx * adx;
    sqy    = ady * ady;
    sum_sq = {1'b0, sqx} + {1'b0, sqy};
    // The index in the low bits makes equal distances rank the lower index first.
    key    = {sum_sq, jidx};
    take   = (!have_prev || key > prev_key) && (!found || key < best_key);
  end
endmodule

>>> design/tomek_link_clean_knn_classify.sv
// Top level: point storage, cleaning and voting sequencer, and APB register.
// Loading: one point per cycle, in_ready high in idle.
// On the last point the sequencer runs alone, with in_ready low. Each distance
// is a memory read, then a compare in the shared distance unit.
// Reset (rst_n low, synchronous) empties the set and sets k_neighbors to 10.
module tomek_link_clean_knn_classify
  import tlk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_coord_x,
  input  logic [COORD_BITS-1:0] in_coord_y,
  input  logic                  in_class_label,
  input  logic                  in_last_point,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CNT_W-1:0]      out_correct_count,
  output logic [CNT_W-1:0]      out_kept_count,
  output logic [CNT_W-1:0]      out_removed_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  `include "tomek_link_clean_knn_classify_assert.svh"

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_NN_I    = 11'b00000000010,
    S_NN_LD   = 11'b00000000100,
    S_SCAN    = 11'b00000001000,
    S_SCAN_EV = 11'b00000010000,
    S_DEL_I   = 11'b00000100000,
    S_DEL_EV  = 11'b00001000000,
    S_VOTE_I  = 11'b00010000000,
    S_V_LD    = 11'b00100000000,
    S_V_RND   = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]        j_r, j_nxt;
  logic [MAX_POINTS-1:0]   del_r, del_nxt;
  logic [MAX_POINTS-1:0]   hasnn_r, hasnn_nxt;
  logic                    changed_r, changed_nxt;
  logic                    vmode_r, vmode_nxt;
  logic [COORD_BITS-1:0]   xi_r, xi_nxt, yi_r, yi_nxt;
  logic                    li_r, li_nxt;
  logic                    found_r, found_nxt;
  logic [KEY_W-1:0]        best_key_r, best_key_nxt;
  logic                    best_lbl_r, best_lbl_nxt;
  logic [KEY_W-1:0]        prev_key_r, prev_key_nxt;
  logic                    have_prev_r, have_prev_nxt;
  logic [3:0]              round_r, round_nxt;
  logic [3:0]              plus_r, plus_nxt, minus_r, minus_nxt;
  logic [CNT_W-1:0]        correct_r, correct_nxt;
  logic [CNT_W-1:0]        kept_r, kept_nxt;
  logic [CNT_W-1:0]        removed_r, removed_nxt;
  logic [3:0]              k_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]        out_correct_r, out_correct_nxt;
  logic [CNT_W-1:0]        out_kept_r, out_kept_nxt;
  logic [CNT_W-1:0]        out_removed_r, out_removed_nxt;

  logic                    pt_we;
  logic [IDX_W-1:0]        pt_raddr;
  logic [PT_W-1:0]         pt_wdata, pt_rdata;
  logic                    nn_we;
  logic [NN_W-1:0]         nn_wdata, nn_rdata;
  logic [KEY_W-1:0]        cand_key;
  logic                    cand_take;
  logic                    accept;
  logic                    cfg_write;
  logic [IDX_W-1:0]        nb;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_K_NEIGHBORS);
  assign prdata    = (paddr[2] == REG_K_NEIGHBORS) ? {28'd0, k_r} : 32'd0;

  assign out_valid         = out_valid_r;
  assign out_correct_count = out_correct_r;
  assign out_kept_count    = out_kept_r;
  assign out_removed_count = out_removed_r;

  assign pt_we    = accept && (cnt_r < CNT_W'(MAX_POINTS));
  assign pt_wdata = {in_class_label, in_coord_y, in_coord_x};
  assign pt_raddr = (state_r == S_SCAN) ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];
  assign nn_we    = (state_r == S_SCAN) && (j_r == cnt_r) && !vmode_r;
  assign nn_wdata = {best_key_r[IDX_W-1:0], best_lbl_r != li_r};
  assign nb       = nn_rdata[NN_W-1:1];

  tlk_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // Per point: nearest live neighbor and whether its class differs.
  tlk_ram #(.WIDTH(NN_W), .DEPTH(MAX_POINTS)) u_nn_ram (
    .clk   (clk),
    .we    (nn_we),
    .waddr (i_r[IDX_W-1:0]),
    .wdata (nn_wdata),
    .raddr (i_r[IDX_W-1:0]),
    .rdata (nn_rdata)
  );

  tlk_dist u_dist (
    .xi        (xi_r),
    .yi        (yi_r),
    .xj        (pt_rdata[COORD_BITS-1:0]),
    .yj        (pt_rdata[2*COORD_BITS-1:COORD_BITS]),
    .jidx      (j_r[IDX_W-1:0]),
    .have_prev (have_prev_r),
    .prev_key  (prev_key_r),
    .found     (found_r),
    .best_key  (best_key_r),
    .key       (cand_key),
    .take      (cand_take)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    del_nxt         = del_r;
    hasnn_nxt       = hasnn_r;
    changed_nxt     = changed_r;
    vmode_nxt       = vmode_r;
    xi_nxt          = xi_r;
    yi_nxt          = yi_r;
    li_nxt          = li_r;
    found_nxt       = found_r;
    best_key_nxt    = best_key_r;
    best_lbl_nxt    = best_lbl_r;
    prev_key_nxt    = prev_key_r;
    have_prev_nxt   = have_prev_r;
    round_nxt       = round_r;
    plus_nxt        = plus_r;
    minus_nxt       = minus_r;
    correct_nxt     = correct_r;
    kept_nxt        = kept_r;
    removed_nxt     = removed_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_correct_nxt = out_correct_r;
    out_kept_nxt    = out_kept_r;
    out_removed_nxt = out_removed_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (pt_we) begin
            del_nxt[cnt_r[IDX_W-1:0]] = 1'b0;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_last_point) begin
            i_nxt       = '0;
            changed_nxt = 1'b0;
            vmode_nxt   = 1'b0;
            state_nxt   = S_NN_I;
          end
        end
      end
      S_NN_I: begin
        if (i_r == cnt_r) begin
          i_nxt     = '0;
          state_nxt = S_DEL_I;
        end else if (del_r[i_r[IDX_W-1:0]]) begin
          hasnn_nxt[i_r[IDX_W-1:0]] = 1'b0;
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = S_NN_LD;
        end
      end
      S_NN_LD: begin
        xi_nxt        = pt_rdata[COORD_BITS-1:0];
        yi_nxt        = pt_rdata[2*COORD_BITS-1:COORD_BITS];
        li_nxt        = pt_rdata[PT_W-1];
        j_nxt         = '0;
        found_nxt     = 1'b0;
        have_prev_nxt = 1'b0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (j_r == cnt_r) begin
          if (!vmode_r) begin
            hasnn_nxt[i_r[IDX_W-1:0]] = found_r;
            i_nxt     = i_r + 1'b1;
            state_nxt = S_NN_I;
          end else if (found_r) begin
            if (best_lbl_r) begin
              plus_nxt = plus_r + 1'b1;
            end else begin
              minus_nxt = minus_r + 1'b1;
            end
            prev_key_nxt  = best_key_r;
            have_prev_nxt = 1'b1;
            round_nxt     = round_r + 1'b1;
            state_nxt     = S_V_RND;
          end else begin
            // Fewer live neighbors than k: the vote closes with what it has.
            if ((plus_r > minus_r) == li_r) begin
              correct_nxt = correct_r + 1'b1;
            end
            i_nxt     = i_r + 1'b1;
            state_nxt = S_VOTE_I;
          end
        end else if (j_r == i_r || del_r[j_r[IDX_W-1:0]]) begin
          j_nxt = j_r + 1'b1;
        end else begin
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (cand_take) begin
          found_nxt    = 1'b1;
          best_key_nxt = cand_key;
          best_lbl_nxt = pt_rdata[PT_W-1];
        end
        j_nxt     = j_r + 1'b1;
        state_nxt = S_SCAN;
      end
      S_DEL_I: begin
        if (i_r == cnt_r) begin
          i_nxt = '0;
          if (changed_r) begin
            changed_nxt = 1'b0;
            state_nxt   = S_NN_I;
          end else begin
            vmode_nxt   = 1'b1;
            correct_nxt = '0;
            kept_nxt    = '0;
            removed_nxt = '0;
            state_nxt   = S_VOTE_I;
          end
        end else if (!hasnn_r[i_r[IDX_W-1:0]] || del_r[i_r[IDX_W-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = S_DEL_EV;
        end
      end
      S_DEL_EV: begin
        // The neighbor found at pass start counts only while it is still live.
        if (!del_r[nb] && nn_rdata[0]) begin
          del_nxt[i_r[IDX_W-1:0]] = 1'b1;
          del_nxt[nb]             = 1'b1;
          changed_nxt             = 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_DEL_I;
      end
      S_VOTE_I: begin
        if (i_r == cnt_r) begin
          state_nxt = S_DONE;
        end else if (del_r[i_r[IDX_W-1:0]]) begin
          removed_nxt = removed_r + 1'b1;
          i_nxt       = i_r + 1'b1;
        end else begin
          state_nxt = S_V_LD;
        end
      end
      S_V_LD: begin
        xi_nxt        = pt_rdata[COORD_BITS-1:0];
        yi_nxt        = pt_rdata[2*COORD_BITS-1:COORD_BITS];
        li_nxt        = pt_rdata[PT_W-1];
        kept_nxt      = kept_r + 1'b1;
        round_nxt     = '0;
        plus_nxt      = '0;
        minus_nxt     = '0;
        have_prev_nxt = 1'b0;
        state_nxt     = S_V_RND;
      end
      S_V_RND: begin
        if (round_r == k_r) begin
          if ((plus_r > minus_r) == li_r) begin
            correct_nxt = correct_r + 1'b1;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = S_VOTE_I;
        end else begin
          // Each round finds the next nearest neighbor beyond the previous one.
          j_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_correct_nxt = correct_r;
          out_kept_nxt    = kept_r;
          out_removed_nxt = removed_r;
          cnt_nxt         = '0;
          del_nxt         = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      del_r       <= '0;
      out_valid_r <= 1'b0;
      k_r         <= K_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      del_r       <= del_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        k_r <= pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    hasnn_r       <= hasnn_nxt;
    changed_r     <= changed_nxt;
    vmode_r       <= vmode_nxt;
    xi_r          <= xi_nxt;
    yi_r          <= yi_nxt;
    li_r          <= li_nxt;
    found_r       <= found_nxt;
    best_key_r    <= best_key_nxt;
    best_lbl_r    <= best_lbl_nxt;
    prev_key_r    <= prev_key_nxt;
    have_prev_r   <= have_prev_nxt;
    round_r       <= round_nxt;
    plus_r        <= plus_nxt;
    minus_r       <= minus_nxt;
    correct_r     <= correct_nxt;
    kept_r        <= kept_nxt;
    removed_r     <= removed_nxt;
    out_correct_r <= out_correct_nxt;
    out_kept_r    <= out_kept_nxt;
    out_removed_r <= out_removed_nxt;
  end

  `TLK_ASSERT_IMP(a_counts_fit, out_valid_r, (out_kept_r + out_removed_r) <= CNT_W'(MAX_POINTS))
  `TLK_ASSERT_IMP(a_correct_le_kept, out_valid_r, out_correct_r <= out_kept_r)
  `TLK_ASSERT_IMP(a_del_in_range, state_r == S_DEL_EV, i_r < cnt_r)
  `TLK_ASSERT_IMP(a_round_le_k, state_r == S_V_RND, round_r <= k_r)
  `TLK_ASSERT_NXT(a_done_clears, state_r == S_DONE && state_nxt == S_IDLE, del_r == '0)
endmodule
